@@ hdl/b2d_pkg.sv @@
// Shared constants and types for the binary to decimal ASCII digit converter.
package b2d_pkg;

   localparam int VALUE_BITS = 32;
   // Decimal digits of 2**VALUE_BITS - 1: floor(VALUE_BITS * log10(2)) + 1.
   localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS   = 4 * NUM_DIGITS;
   localparam int CNT_BITS   = $clog2(VALUE_BITS);
   localparam int REM_BITS   = $clog2(NUM_DIGITS + 1);
   localparam int CHAR_BITS  = 6;

   localparam logic [3:0]           DEC_BASE   = 4'd10;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_SHIFT,
      CONV_DONE
   } conv_state_type;

   // Finished BCD word handed from converter to emitter.
   typedef struct packed {
      logic                valid;
      logic [BCD_BITS-1:0] bcd;
   } bcd_handoff_type;

endpackage

@@ hdl/b2d_dabble.sv @@
// Shift-and-add-3 converter: one binary bit enters the BCD register per cycle.
module b2d_dabble (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [b2d_pkg::VALUE_BITS-1:0]      req_value,
   output b2d_pkg::bcd_handoff_type            hand,
   input  logic                                emit_ready
);
   import b2d_pkg::*;

   conv_state_type          state_ff, state_in;
   logic [VALUE_BITS-1:0]   bin_ff, bin_in;
   logic [BCD_BITS-1:0]     bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]     adj;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CONV_IDLE:  if (req_valid) state_in = CONV_SHIFT;
         CONV_SHIFT: if (cnt_ff == '0) state_in = CONV_DONE;
         CONV_DONE:  if (emit_ready) state_in = CONV_IDLE;
         default:    state_in = CONV_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != CONV_IDLE);
      hand.valid = (state_ff == CONV_DONE);
      hand.bcd   = bcd_ff;
   end

   // Each digit of 5 or more gets 3 added before the shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5)
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         else
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (state_ff == CONV_IDLE && req_valid) begin
         bin_in = req_value;
         bcd_in = '0;
         cnt_in = CNT_BITS'(VALUE_BITS - 1);
      end else if (state_ff == CONV_SHIFT) begin
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   a_shift_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CONV_SHIFT && cnt_ff == '0) |=> state_ff == CONV_DONE)
      else $error("converter did not finish after last shift");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CONV_DONE && !emit_ready) |=> (state_ff == CONV_DONE && $stable(bcd_ff)))
      else $error("finished BCD word lost before handoff");

   a_digits_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == CONV_DONE |-> bcd_ff[3:0] < DEC_BASE)
      else $error("converter produced a non-decimal digit");

endmodule

@@ hdl/b2d_emit.sv @@
// Shifts the BCD word out one digit per cycle unless stalled, dropping leading zeros.
module b2d_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  b2d_pkg::bcd_handoff_type            hand,
   output logic                                emit_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [b2d_pkg::CHAR_BITS-1:0]       rsp_digit_char,
   output logic                                rsp_last_digit
);
   import b2d_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  started_ff, started_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [REM_BITS-1:0]   remain_ff, remain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  char_ff, char_in;
   logic                  last_ff, last_in;

   logic [3:0] top_digit;
   logic       is_last;
   logic       show;
   logic       slot_free;
   logic       advance;
   logic       emit;
   logic       load;

   always_comb begin
      top_digit  = bcd_ff[BCD_BITS-1 -: 4];
      is_last    = (remain_ff == REM_BITS'(1));
      show       = started_ff || (top_digit != 4'd0) || is_last;
      slot_free  = !rsp_valid_ff || !rsp_stall;
      advance    = busy_ff && (!show || slot_free);
      emit       = advance && show;
      emit_ready = !busy_ff;
      load       = hand.valid && !busy_ff;
   end

   always_comb begin
      busy_in    = busy_ff;
      started_in = started_ff;
      bcd_in     = bcd_ff;
      remain_in  = remain_ff;
      if (load) begin
         busy_in    = 1'b1;
         started_in = 1'b0;
         bcd_in     = hand.bcd;
         remain_in  = REM_BITS'(NUM_DIGITS);
      end else if (advance) begin
         started_in = started_ff || show;
         bcd_in     = {bcd_ff[BCD_BITS-5:0], 4'd0};
         remain_in  = remain_ff - 1'b1;
         if (is_last) busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         char_in      = ASCII_ZERO + {2'b00, top_digit};
         last_in      = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      started_ff <= started_in;
      bcd_ff     <= bcd_in;
      remain_ff  <= remain_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (char_ff >= ASCII_ZERO && char_ff <= ASCII_ZERO + 6'd9))
      else $error("emitted character is not a decimal digit");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (advance && is_last) |=> !busy_ff)
      else $error("emitter still busy after last digit");

   a_busy_has_digits: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> remain_ff != '0)
      else $error("emitter busy with no digits left");

endmodule

@@ hdl/binary_to_decimal_ascii_digits.sv @@
// Top level: converts a binary number to ASCII decimal digits, most significant first.
// The first digit passes through the bit-serial shift loop, the handoff and the output register;
// each suppressed leading zero delays it further.
// The shift loop finishes one item before it accepts the next; digit emission
// overlaps the next conversion unless the receiver stalls.
// Reset (synchronous, active high) empties converter and emitter; items in flight are dropped.
module binary_to_decimal_ascii_digits (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [b2d_pkg::VALUE_BITS-1:0]      req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [b2d_pkg::CHAR_BITS-1:0]       rsp_digit_char,
   output logic                                rsp_last_digit
);
   import b2d_pkg::*;

   bcd_handoff_type hand;
   logic            emit_ready;

   b2d_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .hand       (hand),
      .emit_ready (emit_ready)
   );

   b2d_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .hand           (hand),
      .emit_ready     (emit_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the binary to decimal ASCII digit converter.
`timescale 1ns / 1ps

module testbench;
   import b2d_pkg::*;

   typedef struct {
      logic [CHAR_BITS-1:0] digit_char;
      logic                 last_digit;
   } digit_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAR_BITS-1:0]  rsp_digit_char;
   logic                  rsp_last_digit;

   digit_item_type expected_digits[$];
   int             error_count = 0;
   bit             sender_idles = 1'b1;
   bit             receiver_idles = 1'b1;
   int             hold_off_cycles = 0;

   binary_to_decimal_ascii_digits dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Decimal digits of one number, most significant first, leading zeros dropped.
   function automatic void predict_digits(input logic [VALUE_BITS-1:0] value);
      longint unsigned rest;
      int              digit_count;
      int              digits[20];
      digit_item_type  entry;
      rest = 64'(value);
      digit_count = 0;
      do begin
         digits[digit_count] = int'(rest % DEC_BASE);
         rest = rest / DEC_BASE;
         digit_count++;
      end while (rest != 0);
      for (int k = digit_count - 1; k >= 0; k--) begin
         entry.digit_char = ASCII_ZERO + CHAR_BITS'(digits[k]);
         entry.last_digit = (k == 0);
         expected_digits.push_back(entry);
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 9);
      if (!sender_idles || roll < 5) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Called at a rising edge; returns at the edge where the item is accepted.
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      predict_digits(value);
   endtask

   task automatic wait_for_drain();
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (VALUE_BITS + 30) @(posedge clock);
   endtask

   // Receiver side: random stall runs, or a long hold-off when one is requested.
   initial begin
      int  stall_left;
      bit  stall_now;
      stall_left = 0;
      stall_now = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (receiver_idles) begin
            if (stall_left == 0) begin
               stall_now = ($urandom_range(0, 2) == 0);
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
            end
            rsp_stall <= stall_now;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      digit_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                     $time, rsp_digit_char, rsp_last_digit);
            error_count++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_digit_char !== want.digit_char) begin
               $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                        $time, want.digit_char, rsp_digit_char);
               error_count++;
            end
            if (rsp_last_digit !== want.last_digit) begin
               $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                        $time, want.last_digit, rsp_last_digit);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      logic [VALUE_BITS-1:0] corner[$];
      corner = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
                 32'd4294967295, 32'd4294967294, 32'd1000000000, 32'd999999999,
                 32'd4000000000, 32'h80000000, 32'hAAAAAAAA, 32'h55555555,
                 32'd1234567890, 32'd10000, 32'd65535, 32'd3999999999, 32'd0};
      foreach (corner[i]) send_value(corner[i]);
   endtask

   task automatic test_random(input int item_count);
      logic [VALUE_BITS-1:0] value;
      longint unsigned       power;
      for (int i = 0; i < item_count; i++) begin
         case ($urandom_range(0, 5))
            0, 1: value = $urandom;
            2: value = $urandom >> $urandom_range(1, 31);
            3: begin
               // neighbors of powers of ten stress the digit count boundary
               power = 1;
               repeat ($urandom_range(0, 9)) power = power * 10;
               value = VALUE_BITS'(power - 1 + $urandom_range(0, 2));
            end
            4: value = $urandom_range(0, 9);
            default: value = 32'hFFFFFFFF - $urandom_range(0, 1000);
         endcase
         send_value(value);
      end
   endtask

   task automatic test_back_to_back();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      for (int i = 0; i < 20; i++) send_value($urandom);
      req_valid <= 1'b0;
      wait_for_drain();
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Receiver holds off while items keep coming, so the block backs up.
   task automatic test_output_hold_off();
      sender_idles = 1'b0;
      hold_off_cycles = 400;
      for (int i = 0; i < 12; i++) send_value($urandom);
      sender_idles = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(90);
      test_back_to_back();
      test_output_hold_off();
      test_random(8);
      req_valid <= 1'b0;
      wait_for_drain();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/b2d_pkg.sv
hdl/b2d_dabble.sv
hdl/b2d_emit.sv
hdl/binary_to_decimal_ascii_digits.sv
tb/testbench.sv
